/* design/tga_truecolor_stream_decoder_core_macros.svh */
// Assertion macros for the TGA true-color stream decoder.
// Expects clk_i and rst_ni in the scope of the module that uses them.
`ifndef TGA_TRUECOLOR_STREAM_DECODER_CORE_MACROS_SVH
`define TGA_TRUECOLOR_STREAM_DECODER_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TGAD_ASSERT_SAME(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("tgad assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define TGAD_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("tgad assertion failed");

`endif

/* design/tgad_pkg.sv */
// Shared types and constants for the TGA true-color stream decoder.
// No dependencies.
package tgad_pkg;

  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_PIXEL  = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  localparam logic [1:0] ERR_NONE       = 2'd0;
  localparam logic [1:0] ERR_SIGNATURE  = 2'd1;
  localparam logic [1:0] ERR_RESOLUTION = 2'd2;
  localparam logic [1:0] ERR_DEPTH      = 2'd3;

  localparam int unsigned SIG_LEN = 12;
  localparam logic [7:0] SIG_TYPE_BYTE = 8'd2;
  localparam logic [7:0] ALPHA_OPAQUE  = 8'd255;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  error_code;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [8:0]  column;
    logic [8:0]  row;
    logic [17:0] address;
    logic [9:0]  width;
    logic [9:0]  height;
    logic        last;
  } result_t;

  // Signature byte expected at a header position; the pattern repeats every four bytes.
  function automatic logic [7:0] sig_byte(input logic [1:0] pos);
    sig_byte = (pos == 2'd2) ? SIG_TYPE_BYTE : 8'd0;
  endfunction

endpackage

/* design/tga_truecolor_stream_decoder_core.sv */
// Top level of the TGA true-color stream decoder: header parser, pixel assembler, result register.
// Depends on tgad_pkg and tga_truecolor_stream_decoder_core_macros.svh.
//
// Takes one file byte per clock cycle on the input channel; start_of_file_i restarts the
// parser on that byte. Each byte is handled in the cycle it transfers and any result lands in
// a single output register in the next cycle, so the block sustains one byte per cycle while
// out_ready_i stays high; a stalled result holds the input off until it is taken. Results:
// header accepted (with width and height), an error code, or one RGBA pixel per 3 or 4 bytes
// with column, top-down row, word address and a last flag. After an error or the last pixel,
// bytes without the start flag produce nothing.
module tga_truecolor_stream_decoder_core #(
  parameter int unsigned MAX_WIDTH  = 512,
  parameter int unsigned MAX_HEIGHT = 512
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        start_of_file_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [1:0]  error_code_o,
  output logic [7:0]  red_o,
  output logic [7:0]  green_o,
  output logic [7:0]  blue_o,
  output logic [7:0]  alpha_o,
  output logic [8:0]  column_o,
  output logic [8:0]  row_o,
  output logic [17:0] address_o,
  output logic [9:0]  width_o,
  output logic [9:0]  height_o,
  output logic        last_o
);
  import tgad_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned RW = $clog2(MAX_HEIGHT + 1);
  localparam logic [15:0] MAX_W16 = 16'(MAX_WIDTH);
  localparam logic [15:0] MAX_H16 = 16'(MAX_HEIGHT);

  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_SIG   = 3'd1;
  localparam logic [2:0] PH_SIZE  = 3'd2;
  localparam logic [2:0] PH_DEPTH = 3'd3;
  localparam logic [2:0] PH_DESC  = 3'd4;
  localparam logic [2:0] PH_PIX   = 3'd5;
  localparam logic [2:0] PH_DONE  = 3'd6;

  logic [2:0]    phase_q, phase_d;
  logic [3:0]    hdr_cnt_q, hdr_cnt_d;
  logic [15:0]   width_raw_q, width_raw_d;
  logic [15:0]   height_raw_q, height_raw_d;
  logic          four_bytes_q, four_bytes_d;
  logic [1:0]    byte_idx_q, byte_idx_d;
  logic [7:0]    held_blue_q, held_blue_d;
  logic [7:0]    held_green_q, held_green_d;
  logic [7:0]    held_red_q, held_red_d;
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] src_row_q, src_row_d;
  logic [17:0]   row_base_q, row_base_d;
  logic          out_valid_q;
  result_t       res_q, res_d;
  logic          res_valid;

  logic          in_fire;
  logic [2:0]    ph;
  logic [3:0]    hc;
  logic [15:0]   w_new, h_new;
  logic [31:0]   base_prod;
  logic [4:0]    depth_bytes;
  logic          row_end, last_pix;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  assign base_prod   = 32'(height_raw_q - 16'd1) * 32'(width_raw_q);
  assign depth_bytes = data_byte_i[7:3];
  assign row_end     = (17'(col_q) + 17'd1) >= {1'b0, width_raw_q};
  assign last_pix    = row_end && ((17'(src_row_q) + 17'd1) >= {1'b0, height_raw_q});

  always_comb begin
    phase_d      = phase_q;
    hdr_cnt_d    = hdr_cnt_q;
    width_raw_d  = width_raw_q;
    height_raw_d = height_raw_q;
    four_bytes_d = four_bytes_q;
    byte_idx_d   = byte_idx_q;
    held_blue_d  = held_blue_q;
    held_green_d = held_green_q;
    held_red_d   = held_red_q;
    col_d        = col_q;
    src_row_d    = src_row_q;
    row_base_d   = row_base_q;
    res_valid    = 1'b0;
    res_d        = '0;
    ph           = start_of_file_i ? PH_SIG : phase_q;
    hc           = start_of_file_i ? 4'd0 : hdr_cnt_q;
    w_new        = width_raw_q;
    h_new        = height_raw_q;
    if (in_fire) begin
      phase_d   = ph;
      hdr_cnt_d = hc;
      unique case (ph)
        PH_SIG: begin
          if (data_byte_i != sig_byte(hc[1:0])) begin
            res_valid        = 1'b1;
            res_d.kind       = KIND_ERROR;
            res_d.error_code = ERR_SIGNATURE;
            phase_d          = PH_IDLE;
          end else if (hc == 4'(SIG_LEN - 1)) begin
            hdr_cnt_d = 4'd0;
            phase_d   = PH_SIZE;
          end else begin
            hdr_cnt_d = hc + 4'd1;
          end
        end
        PH_SIZE: begin
          unique case (hc[1:0])
            2'd0: w_new = {width_raw_q[15:8], data_byte_i};
            2'd1: w_new = {data_byte_i, width_raw_q[7:0]};
            2'd2: h_new = {height_raw_q[15:8], data_byte_i};
            2'd3: h_new = {data_byte_i, height_raw_q[7:0]};
          endcase
          width_raw_d  = w_new;
          height_raw_d = h_new;
          if (hc[1:0] == 2'd3) begin
            hdr_cnt_d = 4'd0;
            if (w_new == 16'd0 || w_new > MAX_W16 || h_new == 16'd0 || h_new > MAX_H16) begin
              res_valid        = 1'b1;
              res_d.kind       = KIND_ERROR;
              res_d.error_code = ERR_RESOLUTION;
              phase_d          = PH_IDLE;
            end else begin
              phase_d = PH_DEPTH;
            end
          end else begin
            hdr_cnt_d = hc + 4'd1;
          end
        end
        PH_DEPTH: begin
          if (depth_bytes != 5'd3 && depth_bytes != 5'd4) begin
            res_valid        = 1'b1;
            res_d.kind       = KIND_ERROR;
            res_d.error_code = ERR_DEPTH;
            phase_d          = PH_IDLE;
          end else begin
            four_bytes_d = (depth_bytes == 5'd4);
            phase_d      = PH_DESC;
          end
        end
        PH_DESC: begin
          phase_d      = PH_PIX;
          byte_idx_d   = 2'd0;
          col_d        = '0;
          src_row_d    = '0;
          row_base_d   = base_prod[17:0];
          res_valid    = 1'b1;
          res_d.kind   = KIND_HEADER;
          res_d.width  = 10'(width_raw_q);
          res_d.height = 10'(height_raw_q);
        end
        PH_PIX: begin
          priority if (byte_idx_q == 2'd0) begin
            held_blue_d = data_byte_i;
            byte_idx_d  = 2'd1;
          end else if (byte_idx_q == 2'd1) begin
            held_green_d = data_byte_i;
            byte_idx_d   = 2'd2;
          end else if (byte_idx_q == 2'd2 && four_bytes_q) begin
            held_red_d = data_byte_i;
            byte_idx_d = 2'd3;
          end else begin
            byte_idx_d    = 2'd0;
            res_valid     = 1'b1;
            res_d.kind    = KIND_PIXEL;
            res_d.green   = held_green_q;
            res_d.blue    = held_blue_q;
            if (byte_idx_q == 2'd2) begin
              held_red_d  = data_byte_i;
              res_d.red   = data_byte_i;
              res_d.alpha = ALPHA_OPAQUE;
            end else begin
              res_d.red   = held_red_q;
              res_d.alpha = data_byte_i;
            end
            res_d.column  = 9'(col_q);
            res_d.row     = 9'(height_raw_q - 16'd1 - 16'(src_row_q));
            res_d.address = row_base_q + 18'(col_q);
            res_d.last    = last_pix;
            priority if (last_pix) begin
              phase_d = PH_DONE;
            end else if (row_end) begin
              col_d      = '0;
              src_row_d  = src_row_q + RW'(1);
              row_base_d = row_base_q - 18'(width_raw_q);
            end else begin
              col_d = col_q + CW'(1);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      hdr_cnt_q    <= '0;
      width_raw_q  <= '0;
      height_raw_q <= '0;
      four_bytes_q <= 1'b0;
      byte_idx_q   <= '0;
      held_blue_q  <= '0;
      held_green_q <= '0;
      held_red_q   <= '0;
      col_q        <= '0;
      src_row_q    <= '0;
      row_base_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      hdr_cnt_q    <= hdr_cnt_d;
      width_raw_q  <= width_raw_d;
      height_raw_q <= height_raw_d;
      four_bytes_q <= four_bytes_d;
      byte_idx_q   <= byte_idx_d;
      held_blue_q  <= held_blue_d;
      held_green_q <= held_green_d;
      held_red_q   <= held_red_d;
      col_q        <= col_d;
      src_row_q    <= src_row_d;
      row_base_q   <= row_base_d;
      if (in_ready_o) begin
        out_valid_q <= in_fire && res_valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && res_valid) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign kind_o       = res_q.kind;
  assign error_code_o = res_q.error_code;
  assign red_o        = res_q.red;
  assign green_o      = res_q.green;
  assign blue_o       = res_q.blue;
  assign alpha_o      = res_q.alpha;
  assign column_o     = res_q.column;
  assign row_o        = res_q.row;
  assign address_o    = res_q.address;
  assign width_o      = res_q.width;
  assign height_o     = res_q.height;
  assign last_o       = res_q.last;

`include "tga_truecolor_stream_decoder_core_macros.svh"

  `TGAD_ASSERT_SAME(a_last_done, out_valid_q && res_q.kind == KIND_PIXEL && res_q.last, phase_q == PH_DONE)
  `TGAD_ASSERT_SAME(a_hdr_pix, out_valid_q && res_q.kind == KIND_HEADER, phase_q == PH_PIX && byte_idx_q == 2'd0)
  `TGAD_ASSERT_SAME(a_err_idle, out_valid_q && res_q.kind == KIND_ERROR, phase_q == PH_IDLE && res_q.error_code != ERR_NONE)
  `TGAD_ASSERT_NEXT(a_start_no_pix, in_fire && start_of_file_i, !(out_valid_q && res_q.kind == KIND_PIXEL))

endmodule
